// File: rtl/core/clock_sector_cache_tags_macros.svh
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef CLOCK_SECTOR_CACHE_TAGS_MACROS_SVH
`define CLOCK_SECTOR_CACHE_TAGS_MACROS_SVH

`define CST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define CST_ASSERT_IMP(lbl, ante, cons, msg) \
  `CST_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CST_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = 6;
  localparam int SEC_W   = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_DEMAND   = 2'd0,
    KIND_PREFETCH = 2'd1,
    KIND_FLUSH    = 2'd2
  } kind_e;

  // update of the per-entry state bits, all at one index
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             set_valid;
    logic             clr_valid;
    logic             set_dirty;
    logic             clr_dirty;
    logic             set_acc;
    logic             clr_acc;
  } flag_cmd_t;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic accessed;
    logic dirty_above;
  } flag_sts_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              writeback_valid;
    logic [SEC_W-1:0]  writeback_sector;
    logic              fill_valid;
    logic [SEC_W-1:0]  fill_sector;
    logic              last;
  } res_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
    return SLOT_W'(i);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cst_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cst_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [cst_pkg::SEC_W-1:0] sector;

  modport source (output valid, req_type, sector, input ready);
  modport sink   (input valid, req_type, sector, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cst_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cst_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [cst_pkg::SLOT_W-1:0] slot;
  logic                      hit;
  logic                      writeback_valid;
  logic [cst_pkg::SEC_W-1:0]  writeback_sector;
  logic                      fill_valid;
  logic [cst_pkg::SEC_W-1:0]  fill_sector;
  logic                      last;

  modport source (output valid, kind, slot, hit, writeback_valid, writeback_sector,
                  fill_valid, fill_sector, last, input ready);
  modport sink   (input valid, kind, slot, hit, writeback_valid, writeback_sector,
                  fill_valid, fill_sector, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cst_flags.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_flags (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::flag_cmd_t cmd_i,
  output cst_pkg::flag_sts_t sts_o
);

  logic [cst_pkg::ENTRIES-1:0] valid_q;
  logic [cst_pkg::ENTRIES-1:0] dirty_q;
  logic [cst_pkg::ENTRIES-1:0] acc_q;
  logic [cst_pkg::ENTRIES-1:0] above;

  // dirty valid entries past the current index
  always_comb begin
    for (int j = 0; j < cst_pkg::ENTRIES; j++) begin
      above[j] = valid_q[j] && dirty_q[j] && (cst_pkg::IDX_W'(j) > cmd_i.idx);
    end
  end

  assign sts_o.valid       = valid_q[cmd_i.idx];
  assign sts_o.dirty       = dirty_q[cmd_i.idx];
  assign sts_o.accessed    = acc_q[cmd_i.idx];
  assign sts_o.dirty_above = |above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      acc_q   <= '0;
    end else begin
      if (cmd_i.set_valid) begin
        valid_q[cmd_i.idx] <= 1'b1;
      end else if (cmd_i.clr_valid) begin
        valid_q[cmd_i.idx] <= 1'b0;
      end
      if (cmd_i.set_dirty) begin
        dirty_q[cmd_i.idx] <= 1'b1;
      end else if (cmd_i.clr_dirty) begin
        dirty_q[cmd_i.idx] <= 1'b0;
      end
      if (cmd_i.set_acc) begin
        acc_q[cmd_i.idx] <= 1'b1;
      end else if (cmd_i.clr_acc) begin
        acc_q[cmd_i.idx] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cst_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "clock_sector_cache_tags_macros.svh"

module cst_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cst_pkg::SEC_W-1:0] dev_sectors_i,
  input  logic                      req_valid_i,
  input  logic [1:0]                req_type_i,
  input  logic [cst_pkg::SEC_W-1:0] req_sector_i,
  output logic                      req_ready_o,
  input  logic                      res_ready_i,
  output logic                      res_push_o,
  output cst_pkg::res_t             res_o,
  output cst_pkg::flag_cmd_t        flag_cmd_o,
  input  cst_pkg::flag_sts_t        flag_sts_i
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SRD   = 9'b000000010,
    ST_SCMP  = 9'b000000100,
    ST_HIT   = 9'b000001000,
    ST_SWEEP = 9'b000010000,
    ST_VRD   = 9'b000100000,
    ST_MISS  = 9'b001000000,
    ST_FRD   = 9'b010000000,
    ST_FCHK  = 9'b100000000
  } state_e;

  state_e                      state_q, state_d;
  logic [cst_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [cst_pkg::IDX_W-1:0]   hand_q, hand_d;
  logic [cst_pkg::SEC_W-1:0]   sec_q, sec_d;
  cst_pkg::kind_e              kind_q, kind_d;
  logic                        wr_q, wr_d;
  logic                        pre_q, pre_d;

  logic [cst_pkg::SEC_W-1:0]   tag_mem [cst_pkg::ENTRIES];
  logic [cst_pkg::SEC_W-1:0]   tag_rdata_q;
  logic                        tag_re;
  logic                        tag_we;
  logic                        tag_match;
  logic                        victim_dirty;

  assign tag_match    = flag_sts_i.valid && (tag_rdata_q == sec_q);
  assign victim_dirty = flag_sts_i.valid && flag_sts_i.dirty;
  assign req_ready_o  = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[idx_q] <= sec_q;
    end
    if (tag_re) begin
      tag_rdata_q <= tag_mem[idx_q];
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    hand_d     = hand_q;
    sec_d      = sec_q;
    kind_d     = kind_q;
    wr_d       = wr_q;
    pre_d      = pre_q;
    tag_re     = 1'b0;
    tag_we     = 1'b0;
    res_push_o = 1'b0;
    flag_cmd_o     = '0;
    flag_cmd_o.idx = idx_q;
    res_o          = '0;
    res_o.kind     = kind_q;
    res_o.slot     = cst_pkg::to_slot(idx_q);
    res_o.last     = (kind_q == cst_pkg::KIND_PREFETCH) || !pre_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_type_i)
            cst_pkg::REQ_READ, cst_pkg::REQ_WRITE: begin
              sec_d   = req_sector_i;
              kind_d  = cst_pkg::KIND_DEMAND;
              wr_d    = (req_type_i == cst_pkg::REQ_WRITE);
              pre_d   = ((cst_pkg::SEC_W + 1)'(req_sector_i) + (cst_pkg::SEC_W + 1)'(1))
                        < (cst_pkg::SEC_W + 1)'(dev_sectors_i);
              idx_d   = '0;
              state_d = ST_SRD;
            end
            cst_pkg::REQ_FLUSH: begin
              idx_d   = '0;
              state_d = ST_FRD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRD: begin
        tag_re  = 1'b1;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (tag_match) begin
          state_d = ST_HIT;
        end else if (idx_q == cst_pkg::LAST_IDX) begin
          idx_d   = hand_q;
          state_d = ST_SWEEP;
        end else begin
          idx_d   = idx_q + cst_pkg::IDX_W'(1);
          state_d = ST_SRD;
        end
      end
      ST_HIT: begin
        res_o.hit  = 1'b1;
        res_push_o = res_ready_i;
        if (res_ready_i) begin
          if (kind_q == cst_pkg::KIND_DEMAND) begin
            flag_cmd_o.set_acc   = 1'b1;
            flag_cmd_o.set_dirty = wr_q;
          end
          if ((kind_q == cst_pkg::KIND_DEMAND) && pre_q) begin
            sec_d   = sec_q + cst_pkg::SEC_W'(1);
            kind_d  = cst_pkg::KIND_PREFETCH;
            idx_d   = '0;
            state_d = ST_SRD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SWEEP: begin
        // second chance: clear accessed of a valid accessed entry and move on, else take it as victim
        if (!flag_sts_i.valid || !flag_sts_i.accessed) begin
          state_d = ST_VRD;
        end else begin
          flag_cmd_o.clr_acc = 1'b1;
          idx_d              = cst_pkg::next_idx(idx_q);
        end
      end
      ST_VRD: begin
        tag_re  = 1'b1;
        state_d = ST_MISS;
      end
      ST_MISS: begin
        res_o.writeback_valid  = victim_dirty;
        res_o.writeback_sector = victim_dirty ? tag_rdata_q : '0;
        res_o.fill_valid       = 1'b1;
        res_o.fill_sector      = sec_q;
        res_push_o             = res_ready_i;
        if (res_ready_i) begin
          tag_we               = 1'b1;
          hand_d               = cst_pkg::next_idx(idx_q);
          flag_cmd_o.set_valid = 1'b1;
          if (kind_q == cst_pkg::KIND_DEMAND) begin
            flag_cmd_o.set_acc   = 1'b1;
            flag_cmd_o.set_dirty = wr_q;
            flag_cmd_o.clr_dirty = !wr_q;
          end else begin
            flag_cmd_o.clr_acc   = 1'b1;
            flag_cmd_o.clr_dirty = 1'b1;
          end
          if ((kind_q == cst_pkg::KIND_DEMAND) && pre_q) begin
            sec_d   = sec_q + cst_pkg::SEC_W'(1);
            kind_d  = cst_pkg::KIND_PREFETCH;
            idx_d   = '0;
            state_d = ST_SRD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FRD: begin
        tag_re  = 1'b1;
        state_d = ST_FCHK;
      end
      ST_FCHK: begin
        res_o.kind             = cst_pkg::KIND_FLUSH;
        res_o.writeback_valid  = 1'b1;
        res_o.writeback_sector = tag_rdata_q;
        res_o.last             = !flag_sts_i.dirty_above;
        if (!victim_dirty || res_ready_i) begin
          res_push_o           = victim_dirty;
          flag_cmd_o.clr_valid = 1'b1;
          flag_cmd_o.clr_dirty = 1'b1;
          flag_cmd_o.clr_acc   = 1'b1;
          if (idx_q == cst_pkg::LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + cst_pkg::IDX_W'(1);
            state_d = ST_FRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      hand_q  <= '0;
      sec_q   <= '0;
      kind_q  <= cst_pkg::KIND_DEMAND;
      wr_q    <= 1'b0;
      pre_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hand_q  <= hand_d;
      sec_q   <= sec_d;
      kind_q  <= kind_d;
      wr_q    <= wr_d;
      pre_q   <= pre_d;
    end
  end

  `CST_ASSERT_IMP(a_push_has_room, res_push_o, res_ready_i, "result pushed into a full output stage")
  `CST_ASSERT_IMP(a_flush_only_dirty, res_push_o && (state_q == ST_FCHK), victim_dirty, "flush beat for a clean entry")
  `CST_ASSERT_NEXT(a_hand_past_victim, res_push_o && (state_q == ST_MISS), hand_q == cst_pkg::next_idx($past(idx_q)), "clock hand not one past the victim")
  `CST_ASSERT_NEXT(a_idle_after_last, res_push_o && res_o.last && (res_o.kind != cst_pkg::KIND_FLUSH), state_q == ST_IDLE, "engine busy after the last lookup beat")

endmodule

`default_nettype wire

// File: rtl/core/clock_sector_cache_tags.sv
`timescale 1ns / 1ps
`default_nettype none
// Tag and replacement engine of a 64-entry fully associative sector cache with clock
// (second-chance) replacement. One request is taken at a time and req_i.ready stays low
// until its last lookup beat is handed to the output register or a flush has walked every
// entry. All tags sit in a single-port RAM checked by one shared comparator: a lookup reads
// and compares entry after entry from entry 0 and stops at a hit; on a miss the clock hand
// sweeps from its position, clearing accessed bits, visits at most 65 entries, and then
// the victim's tag is read and the fill beat given. A read or write whose next sector lies
// below device_sectors runs a second lookup for the prefetch. A flush walks every entry and
// gives one beat per dirty entry. A full output register stalls the engine at a beat.

module clock_sector_cache_tags (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cst_pkg::SEC_W-1:0] cfg_wdata_i,
  cst_req_if.sink                   req_i,
  cst_res_if.source                 res_o
);

  logic [cst_pkg::SEC_W-1:0] dev_sectors_q;
  cst_pkg::res_t             out_q;
  logic                      out_valid_q;
  logic                      res_ready;
  logic                      res_push;
  cst_pkg::res_t             res;
  cst_pkg::flag_cmd_t        flag_cmd;
  cst_pkg::flag_sts_t        flag_sts;

  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sectors_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_sectors_q <= cfg_wdata_i;
      end
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  cst_flags u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (flag_cmd),
    .sts_o  (flag_sts)
  );

  cst_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dev_sectors_i (dev_sectors_q),
    .req_valid_i   (req_i.valid),
    .req_type_i    (req_i.req_type),
    .req_sector_i  (req_i.sector),
    .req_ready_o   (req_i.ready),
    .res_ready_i   (res_ready),
    .res_push_o    (res_push),
    .res_o         (res),
    .flag_cmd_o    (flag_cmd),
    .flag_sts_i    (flag_sts)
  );

  assign res_o.valid            = out_valid_q;
  assign res_o.kind             = out_q.kind;
  assign res_o.slot             = out_q.slot;
  assign res_o.hit              = out_q.hit;
  assign res_o.writeback_valid  = out_q.writeback_valid;
  assign res_o.writeback_sector = out_q.writeback_sector;
  assign res_o.fill_valid       = out_q.fill_valid;
  assign res_o.fill_sector      = out_q.fill_sector;
  assign res_o.last             = out_q.last;

endmodule

`default_nettype wire

// File: tb/clock_sector_cache_tags_tb.sv
`timescale 1ns / 1ps

module clock_sector_cache_tags_tb;
  import cst_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CLK_HALF = 4;
  localparam int SETTLE_CYCLES = 450;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 300;
  localparam longint TIMEOUT_NS = 64'd16_000_000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [SEC_W-1:0] cfg_wdata;

  cst_req_if req_if ();
  cst_res_if res_if ();

  clock_sector_cache_tags u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // cache model state
  bit line_valid [ENTRIES];
  bit line_dirty [ENTRIES];
  bit line_ref [ENTRIES];
  bit [SEC_W-1:0] line_tag [ENTRIES];
  int hand_pos = 0;
  bit [SEC_W-1:0] dev_sectors = '0;

  res_t pending_beats[$];
  int err_cnt = 0;
  int pend_gap = 0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int rdy_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL clock_sector_cache_tags");
    $finish;
  end

  function automatic int next_line(input int i);
    return (i + 1 >= ENTRIES) ? 0 : i + 1;
  endfunction

  // search, else clock sweep and replace; queues one beat
  task automatic cache_lookup(input bit [SEC_W-1:0] sec, input kind_e k, input bit fin,
                              output int idx);
    res_t r;
    int j;
    bit found;
    found = 1'b0;
    idx = 0;
    r = '0;
    r.kind = k;
    r.last = fin;
    for (j = 0; j < ENTRIES && !found; j++) begin
      if (line_valid[j] && line_tag[j] == sec) begin
        found = 1'b1;
        idx = j;
      end
    end
    if (found) begin
      r.slot = SLOT_W'(idx);
      r.hit = 1'b1;
    end else begin
      idx = hand_pos;
      while (line_valid[idx] && line_ref[idx]) begin
        line_ref[idx] = 1'b0;
        idx = next_line(idx);
      end
      hand_pos = next_line(idx);
      r.slot = SLOT_W'(idx);
      r.writeback_valid = line_valid[idx] && line_dirty[idx];
      r.writeback_sector = r.writeback_valid ? line_tag[idx] : '0;
      r.fill_valid = 1'b1;
      r.fill_sector = sec;
      line_valid[idx] = 1'b1;
      line_dirty[idx] = 1'b0;
      line_ref[idx] = 1'b0;
      line_tag[idx] = sec;
    end
    pending_beats.push_back(r);
  endtask

  task automatic predict_req(input logic [1:0] code, input bit [SEC_W-1:0] sec);
    int s;
    int i;
    int n;
    bit pre;
    res_t r;
    if (code == REQ_READ || code == REQ_WRITE) begin
      pre = ({1'b0, sec} + 33'd1) < {1'b0, dev_sectors};
      cache_lookup(sec, KIND_DEMAND, !pre, s);
      line_ref[s] = 1'b1;
      if (code == REQ_WRITE) line_dirty[s] = 1'b1;
      if (pre) cache_lookup(sec + 32'd1, KIND_PREFETCH, 1'b1, s);
    end else if (code == REQ_FLUSH) begin
      n = 0;
      for (i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && line_dirty[i]) begin
          r = '0;
          r.kind = KIND_FLUSH;
          r.slot = SLOT_W'(i);
          r.writeback_valid = 1'b1;
          r.writeback_sector = line_tag[i];
          pending_beats.push_back(r);
          n++;
        end
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_ref[i] = 1'b0;
        line_tag[i] = '0;
      end
      if (n > 0) pending_beats[pending_beats.size() - 1].last = 1'b1;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_req(input logic [1:0] code, input logic [SEC_W-1:0] sec);
    if (pend_gap > 0) begin
      repeat (pend_gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.req_type = code;
    req_if.sector = sec;
    do @(posedge clk_i); while (!req_if.ready);
    predict_req(code, sec);
    @(negedge clk_i);
    pend_gap = src_gaps ? int'($urandom_range(0, 5)) : 0;
    if (pend_gap > 0) req_if.valid = 1'b0;
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    if (pend_gap == 0) pend_gap = 1;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_dev_sectors(input logic [SEC_W-1:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    dev_sectors = v;
  endtask

  task automatic send_random(input logic [SEC_W-1:0] base, input int span,
                             input int flush_pct);
    int pick;
    logic [1:0] code;
    logic [SEC_W-1:0] sec;
    pick = $urandom_range(0, 99);
    if (pick < flush_pct) code = REQ_FLUSH;
    else if (pick < flush_pct + 2) code = REQ_UNUSED;
    else if (pick < 55) code = REQ_READ;
    else code = REQ_WRITE;
    pick = $urandom_range(0, 99);
    if (pick < 85) sec = base + $urandom_range(0, span);
    else if (pick < 95) sec = $urandom();
    else sec = 32'hFFFF_FFFF - $urandom_range(0, 3);
    send_req(code, sec);
  endtask

  task automatic run_random(input int count, input logic [SEC_W-1:0] base, input int span,
                            input int flush_pct);
    int k;
    for (k = 0; k < count; k++) send_random(base, span, flush_pct);
  endtask

  task automatic test_defaults();
    send_req(REQ_READ, 32'd0);
    send_req(REQ_WRITE, 32'hFFFF_FFFF);
    send_req(REQ_READ, 32'd0);
    send_req(REQ_WRITE, 32'd0);
    send_req(REQ_FLUSH, $urandom());
    send_req(REQ_FLUSH, $urandom());
    send_req(REQ_UNUSED, 32'h1234_5678);
    send_req(REQ_READ, 32'h1234_5678);
  endtask

  task automatic test_prefetch_bound();
    write_dev_sectors(32'hFFFF_FFFF);
    send_req(REQ_READ, 32'd5);
    send_req(REQ_READ, 32'd6);
    send_req(REQ_READ, 32'd5);
    send_req(REQ_WRITE, 32'hFFFF_FFFE);
    send_req(REQ_READ, 32'hFFFF_FFFF);
    send_req(REQ_WRITE, 32'h7FFF_FFFF);
    send_req(REQ_FLUSH, $urandom());
    write_dev_sectors(32'h0000_0100);
    send_req(REQ_READ, 32'h0000_00FE);
    send_req(REQ_READ, 32'h0000_00FF);
    send_req(REQ_WRITE, 32'h0000_0200);
    send_req(REQ_FLUSH, $urandom());
  endtask

  task automatic test_clock_sweep();
    write_dev_sectors(32'd0);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_random(110, $urandom(), 150, 1);
  endtask

  task automatic test_prefetch_burst();
    write_dev_sectors(32'hFFFF_FFFF);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_random(110, $urandom(), 60, 3);
  endtask

  task automatic test_device_edge();
    logic [SEC_W-1:0] base;
    base = $urandom();
    write_dev_sectors(base + 32'd50);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_random(110, base, 100, 2);
  endtask

  task automatic test_backpressure();
    drain();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    rdy_hold = HOLD_CYCLES;
    run_random(20, $urandom(), 30, 5);
  endtask

  task automatic test_wide_random();
    write_dev_sectors($urandom());
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_random(100, $urandom(), 120, 2);
  endtask

  task automatic note_err(input string what, input res_t want, input res_t got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%s at %0t: exp kind=%0d slot=%0d hit=%0b wb=%0b/%h fill=%0b/%h last=%0b",
               what, $time, want.kind, want.slot, want.hit, want.writeback_valid,
               want.writeback_sector, want.fill_valid, want.fill_sector, want.last);
      $display("    got kind=%0d slot=%0d hit=%0b wb=%0b/%h fill=%0b/%h last=%0b",
               got.kind, got.slot, got.hit, got.writeback_valid, got.writeback_sector,
               got.fill_valid, got.fill_sector, got.last);
    end
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    bit bad;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind = kind_e'(res_if.kind);
      got.slot = res_if.slot;
      got.hit = res_if.hit;
      got.writeback_valid = res_if.writeback_valid;
      got.writeback_sector = res_if.writeback_sector;
      got.fill_valid = res_if.fill_valid;
      got.fill_sector = res_if.fill_sector;
      got.last = res_if.last;
      if (pending_beats.size() == 0) begin
        note_err("unexpected beat", '0, got);
      end else begin
        want = pending_beats.pop_front();
        bad = (got.kind !== want.kind) || (got.slot !== want.slot) ||
              (got.hit !== want.hit) || (got.writeback_valid !== want.writeback_valid) ||
              (got.writeback_sector !== want.writeback_sector) ||
              (got.fill_valid !== want.fill_valid) ||
              (got.fill_sector !== want.fill_sector) || (got.last !== want.last);
        if (bad) note_err("beat mismatch", want, got);
      end
    end
  end

  // result sink with random stalls and one long hold
  initial begin
    int n;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = sink_stalls ? int'($urandom_range(0, 5)) : 0;
      if (rdy_hold > 0) begin
        n = rdy_hold;
        rdy_hold = 0;
      end
      if (n > 0) begin
        res_if.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_READ;
    req_if.sector = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_defaults();
    test_prefetch_bound();
    test_clock_sweep();
    test_prefetch_burst();
    test_device_edge();
    test_backpressure();
    test_wide_random();

    drain();
    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("PASS clock_sector_cache_tags");
    end else begin
      $display("FAIL clock_sector_cache_tags");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cst_pkg.sv
rtl/core/cst_req_if.sv
rtl/core/cst_res_if.sv
rtl/core/cst_flags.sv
rtl/core/cst_seq.sv
rtl/core/clock_sector_cache_tags.sv
tb/clock_sector_cache_tags_tb.sv
